[src/mcg_pkg.sv]
package mcg_pkg;

    localparam int GRID_SLOTS  = 42;
    localparam int SLOT_W      = 6;
    localparam int DAY_W       = 9;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 14;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [4:0]         mlen_t;
    typedef logic [2:0]         wday_t;

    localparam slot_idx_t LAST_SLOT = SLOT_W'(GRID_SLOTS - 1);

    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_SEP = 4'd9;
    localparam month_t MONTH_OCT = 4'd10;
    localparam month_t MONTH_DEC = 4'd12;

    localparam year_t YEAR_MIN     = 14'd1;
    localparam year_t YEAR_MAX     = 14'd9999;
    localparam year_t REFORM_YEAR  = 14'd1752;
    localparam year_t GREG_BASE    = 14'd1600;
    localparam year_t CENT_START   = 14'd1700;
    localparam int    CENT_BASE    = 17;

    // reciprocals: x/25 = (x*1311)>>15 for x < 4681, x/7 = (x*18725)>>17 for x < 43690
    localparam logic [10:0] RECIP25    = 11'd1311;
    localparam int          RECIP25_SH = 15;
    localparam logic [14:0] RECIP7     = 15'd18725;
    localparam int          RECIP7_SH  = 17;

    localparam int EPOCH_SHIFT = 5;
    localparam int GAP_SHIFT   = 3;

    // September 1752 layout
    localparam slot_idx_t SEPT_FIRST_SLOT = 6'd2;
    localparam slot_idx_t SEPT_SPLIT_SLOT = 6'd3;
    localparam slot_idx_t SEPT_END_SLOT   = 6'd20;
    localparam slot_idx_t SEPT_SKIP       = 6'd9;
    localparam day_t      SEPT_ORD_BASE   = 9'd245;

    typedef struct packed {
        logic  bad;
        logic  sept;
        logic  ordm;
        wday_t first_wd;
        mlen_t mlen;
        day_t  start;
    } grid_desc_t;

    function automatic mlen_t month_days(month_t m);
        mlen_t d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
            4'd2:                                        d = 5'd28;
            default:                                     d = 5'd0;
        endcase
        return d;
    endfunction

    // days in the year ahead of month m, common year
    function automatic day_t month_cum(month_t m);
        day_t d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[src/mcg_if.sv]
interface mcg_req_if;
    import mcg_pkg::*;

    logic   valid;
    logic   ready;
    month_t month_number;
    year_t  year_number;

    modport source (output valid, month_number, year_number, input ready);
    modport sink   (input valid, month_number, year_number, output ready);
endinterface

interface mcg_slot_if;
    import mcg_pkg::*;

    logic      valid;
    logic      ready;
    day_t      slot_day;
    logic      slot_blank;
    slot_idx_t slot_position;
    logic      bad_request;
    logic      last_slot;

    modport source (output valid, slot_day, slot_blank, slot_position, bad_request, last_slot,
                    input ready);
    modport sink   (input valid, slot_day, slot_blank, slot_position, bad_request, last_slot,
                    output ready);
endinterface

[src/mcg_front.sv]
module mcg_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ordinal_mode,
    mcg_req_if.sink            req,
    output mcg_pkg::grid_desc_t desc,
    output logic               desc_valid,
    input  logic               desc_ready
);
    import mcg_pkg::*;

    logic en;

    // stage 1: captured request
    logic   v1_reg, bad1_reg, sept1_reg, ordm1_reg;
    month_t m1_reg;
    year_t  y1_reg;
    logic   bad_in;

    // stage 2: reciprocal products
    logic        v2_reg, bad2_reg, sept2_reg, ordm2_reg, gt1700_2_reg;
    month_t      m2_reg;
    year_t       y2_reg, p2_reg;
    logic [22:0] prod100_reg, prody_reg;
    logic [20:0] prod400_reg;
    year_t       p1, pdiff;
    logic [11:0] pq1, yq1;
    logic [9:0]  pq16;
    logic        gt1600_1, gt1700_1;

    // stage 3: day count mod-7 operand
    logic        v3_reg, bad3_reg, sept3_reg, ordm3_reg;
    logic [14:0] s3_reg;
    mlen_t       mlen3_reg;
    day_t        start3_reg;
    logic [7:0]  d100, yq25;
    logic [5:0]  d400;
    logic [12:0] leaps;
    logic        y4, c100, c400, leap, after_gap;
    day_t        ord_first;
    mlen_t       mlen3_next;
    logic [14:0] s3_next;

    // stage 4: divide by 7
    logic        v4_reg, bad4_reg, sept4_reg, ordm4_reg;
    logic [14:0] s4_reg;
    logic [29:0] prod7_reg;
    mlen_t       mlen4_reg;
    day_t        start4_reg;
    logic [12:0] quo7;
    logic [14:0] rem7;

    assign en        = !v4_reg || desc_ready;
    assign req.ready = en;

    assign bad_in = (req.month_number < MONTH_JAN) || (req.month_number > MONTH_DEC)
                 || (req.year_number < YEAR_MIN) || (req.year_number > YEAR_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg    <= req.month_number;
            y1_reg    <= req.year_number;
            bad1_reg  <= bad_in;
            sept1_reg <= !bad_in && (req.month_number == MONTH_SEP)
                         && (req.year_number == REFORM_YEAR);
            ordm1_reg <= ordinal_mode;
        end
    end

    // stage 1 -> 2: p = year - 1, quotients feed the /25 reciprocal
    always_comb
    begin
        p1       = y1_reg - 14'd1;
        pdiff    = p1 - GREG_BASE;
        gt1600_1 = p1 > GREG_BASE;
        gt1700_1 = p1 > CENT_START;
        pq1      = p1[13:2];
        yq1      = y1_reg[13:2];
        pq16     = gt1600_1 ? pdiff[13:4] : 10'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod100_reg  <= 23'(pq1) * 23'(RECIP25);
            prody_reg    <= 23'(yq1) * 23'(RECIP25);
            prod400_reg  <= 21'(pq16) * 21'(RECIP25);
            p2_reg       <= p1;
            gt1700_2_reg <= gt1700_1;
            m2_reg       <= m1_reg;
            y2_reg       <= y1_reg;
            bad2_reg     <= bad1_reg;
            sept2_reg    <= sept1_reg;
            ordm2_reg    <= ordm1_reg;
        end
    end

    // stage 2 -> 3: leap days, leap year, ordinal of the 1st, weekday sum
    always_comb
    begin
        d100 = prod100_reg[RECIP25_SH +: 8];
        yq25 = prody_reg[RECIP25_SH +: 8];
        d400 = prod400_reg[RECIP25_SH +: 6];

        leaps = 13'(p2_reg[13:2]) + 13'(d400)
              + (gt1700_2_reg ? (13'(CENT_BASE) - 13'(d100)) : 13'd0);

        y4   = (y2_reg[1:0] == 2'd0);
        c100 = y4 && ({4'd0, y2_reg[13:2]} == 16'(16'(yq25) * 16'd25));
        c400 = c100 && (y2_reg[3:2] == 2'd0);
        leap = (y2_reg <= REFORM_YEAR) ? y4 : (y4 && (!c100 || c400));

        ord_first  = month_cum(m2_reg) + 9'd1 + 9'(leap && (m2_reg > MONTH_FEB));
        mlen3_next = month_days(m2_reg) + 5'(leap && (m2_reg == MONTH_FEB));

        // dates after the reform gap lose 11 days, i.e. gain 3 mod 7
        after_gap = (y2_reg > REFORM_YEAR)
                 || ((y2_reg == REFORM_YEAR) && (m2_reg >= MONTH_OCT));

        // 365 = 1 mod 7, so (p*365 + ...) mod 7 == (p + ...) mod 7
        s3_next = 15'(p2_reg) + 15'(leaps) + 15'(ord_first) + 15'(EPOCH_SHIFT)
                + (after_gap ? 15'(GAP_SHIFT) : 15'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg     <= s3_next;
            mlen3_reg  <= mlen3_next;
            start3_reg <= ordm2_reg ? ord_first : 9'd1;
            bad3_reg   <= bad2_reg;
            sept3_reg  <= sept2_reg;
            ordm3_reg  <= ordm2_reg;
        end
    end

    // stage 4
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod7_reg  <= 30'(s3_reg) * 30'(RECIP7);
            s4_reg     <= s3_reg;
            mlen4_reg  <= mlen3_reg;
            start4_reg <= start3_reg;
            bad4_reg   <= bad3_reg;
            sept4_reg  <= sept3_reg;
            ordm4_reg  <= ordm3_reg;
        end
    end

    always_comb
    begin
        quo7 = prod7_reg[RECIP7_SH +: 13];
        rem7 = s4_reg - 15'(quo7) * 15'd7;

        desc_valid    = v4_reg;
        desc.bad      = bad4_reg;
        desc.sept     = sept4_reg;
        desc.ordm     = ordm4_reg;
        desc.first_wd = rem7[2:0];
        desc.mlen     = mlen4_reg;
        desc.start    = start4_reg;
    end

endmodule

[src/mcg_queue.sv]
module mcg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mcg_pkg::grid_desc_t push_data,
    output logic                full,
    input  logic                pop,
    output mcg_pkg::grid_desc_t pop_data,
    output logic                not_empty
);
    import mcg_pkg::*;

    grid_desc_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/mcg_back.sv]
module mcg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mcg_pkg::grid_desc_t desc,
    input  logic                desc_valid,
    output logic                desc_ready,
    mcg_slot_if.source          slot
);
    import mcg_pkg::*;

    logic       active_reg;
    slot_idx_t  k_reg;
    grid_desc_t d_reg;

    logic       ov_reg, blank_reg, bad_reg, last_reg;
    day_t       day_reg;
    slot_idx_t  pos_reg;

    logic       emit, at_last, load;
    logic       sept_hit, norm_hit, hit;
    slot_idx_t  sept_off, rel;
    day_t       day_val;

    assign emit       = active_reg && (!ov_reg || slot.ready);
    assign at_last    = (k_reg == LAST_SLOT);
    assign load       = !active_reg || (emit && at_last);
    assign desc_ready = load;

    always_comb
    begin
        sept_off = (k_reg <= SEPT_SPLIT_SLOT) ? (k_reg - SEPT_FIRST_SLOT) : (k_reg + SEPT_SKIP);
        sept_hit = d_reg.sept && (k_reg >= SEPT_FIRST_SLOT) && (k_reg <= SEPT_END_SLOT);

        rel      = k_reg - slot_idx_t'(d_reg.first_wd);
        norm_hit = !d_reg.bad && !d_reg.sept && (k_reg >= slot_idx_t'(d_reg.first_wd))
                && (rel < slot_idx_t'(d_reg.mlen));

        hit = sept_hit || norm_hit;
        if (sept_hit)
        begin
            day_val = (d_reg.ordm ? SEPT_ORD_BASE : 9'd1) + 9'(sept_off);
        end
        else if (norm_hit)
        begin
            day_val = d_reg.start + 9'(rel);
        end
        else
        begin
            day_val = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                active_reg <= desc_valid;
                k_reg      <= '0;
            end
            else if (emit)
            begin
                k_reg <= k_reg + 1'b1;
            end

            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (slot.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && desc_valid)
        begin
            d_reg <= desc;
        end
        if (emit)
        begin
            day_reg   <= day_val;
            blank_reg <= !hit;
            pos_reg   <= k_reg;
            bad_reg   <= d_reg.bad;
            last_reg  <= at_last;
        end
    end

    assign slot.valid         = ov_reg;
    assign slot.slot_day      = day_reg;
    assign slot.slot_blank    = blank_reg;
    assign slot.slot_position = pos_reg;
    assign slot.bad_request   = bad_reg;
    assign slot.last_slot     = last_reg;

endmodule

[src/month_calendar_grid_core.sv]
// channel  dir  fields                                              transfer when
// req      in   month_number[3:0] year_number[13:0]                 req.valid & req.ready
// slot     out  slot_day[8:0] slot_blank slot_position[5:0]         slot.valid & slot.ready
//               bad_request last_slot
// cfg      in   cfg_wr_data (ordinal_mode)                          cfg_wr_en
//
// Each request yields 42 slot transfers, one per cycle unless slot.ready stalls them;
// the slot sequencer in the back end sets that rate.
// The first slot follows the request transfer through front stages 2 to 4, the queue,
// the sequencer load and the output reg.
// rst_n is asynchronous; it clears the pipeline valids, the queue and the sequencer.
// The front keeps taking requests while the back streams slots; a stalled slot
// channel fills the queue and then holds req.ready low.
module month_calendar_grid_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    mcg_req_if.sink    req,
    mcg_slot_if.source slot
);
    import mcg_pkg::*;

    // ordinal_mode; sampled per request as it enters the front end
    logic       ordinal_mode_reg;

    // front -> queue
    grid_desc_t front_desc;
    logic       front_valid;
    logic       q_full;

    // queue -> back
    grid_desc_t back_desc;
    logic       back_valid;
    logic       back_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordinal_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            ordinal_mode_reg <= cfg_wr_data;
        end
    end

    // front: range check, leap rules, weekday of the 1st and month length
    mcg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .ordinal_mode (ordinal_mode_reg),
        .req          (req),
        .desc         (front_desc),
        .desc_valid   (front_valid),
        .desc_ready   (!q_full)
    );

    // short queue decouples request classification from slot streaming
    mcg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (back_pop),
        .pop_data  (back_desc),
        .not_empty (back_valid)
    );

    // back: walks the 42 slots of each month through the output register
    mcg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (back_desc),
        .desc_valid (back_valid),
        .desc_ready (back_pop),
        .slot       (slot)
    );

`ifndef ASSERT_OFF
    // last_slot flags exactly the final grid position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        slot.valid |-> (slot.last_slot == (slot.slot_position == LAST_SLOT)))
        else $error("last_slot does not match slot_position");

    // within a grid the next slot follows right after a transfer, one position on
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (slot.valid && slot.ready && !slot.last_slot)
        |=> (slot.valid && (slot.slot_position == $past(slot.slot_position) + 6'd1)))
        else $error("slot sequence broken");

    // bad requests carry only blank slots
    a_bad_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (slot.valid && slot.bad_request) |-> (slot.slot_blank && (slot.slot_day == '0)))
        else $error("bad request produced a day");
`endif

endmodule

[dv/month_calendar_grid_core_test.sv]
`timescale 1ns / 100ps

module month_calendar_grid_core_test;
    import mcg_pkg::*;

    // Every request must come back as 42 slot transfers, Sunday first. The
    // predictor queues those 42 slots at the request transfer; the slot checker
    // compares each slot transfer against the oldest queued slot, field by field.
    // ordinal_mode is only written once the core has gone quiet.

    // calendar constants used by the predictor
    localparam int unsigned JULIAN_LAST_YEAR = 1752;  // Julian leap rule up to here
    localparam int unsigned MISSING_FIRST    = 639787; // day count of 22 Aug 1752
    localparam int unsigned MISSING_DAYS     = 11;     // 3..13 Sep 1752 never happened
    localparam int unsigned YEAR_LAST        = 9999;
    localparam int unsigned SEPT_DAY_BASE    = 1;
    localparam int unsigned SEPT_JUMP        = 9;      // slot k >= 4 shows k + 9 (+ base)
    localparam int unsigned WEEKDAY_IN_GAP   = 4;      // Thursday
    localparam int unsigned SETTLE_CYCLES    = 8;      // above the request-to-slot latency
    localparam int unsigned RANDOM_PER_PHASE = 100;

    typedef struct {
        day_t      day;
        logic      blank;
        slot_idx_t pos;
        logic      bad;
        logic      last;
    } grid_slot_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    mcg_req_if  req_ch ();
    mcg_slot_if slot_ch ();

    month_calendar_grid_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .slot        (slot_ch)
    );

    // predicted slots, oldest first
    grid_slot_t expected_slots[$];

    // predictor copy of the register and of the core's month state
    bit    ordinal_view;
    wday_t pred_first_wd;
    mlen_t pred_month_len;
    day_t  pred_start_day;

    // idle percentages for both channels, changed per phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned bad_requests;
    int unsigned reform_grids;
    int unsigned ordinal_grids;
    int unsigned slots_checked;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------
    function automatic bit is_leap_yr(int unsigned y);
        if (y <= JULIAN_LAST_YEAR)
            return (y % 4) == 0;
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_length_of(int unsigned m, int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap_yr(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // day of year of the 1st of month m
    function automatic int unsigned day_of_year_first(int unsigned m, int unsigned y);
        int unsigned acc;
        int unsigned i;
        acc = 1;
        for (i = 1; i < m && i <= 12; i++)
            acc += month_length_of(i, y);
        return acc;
    endfunction

    // leap days in years 1..p, Julian, with Gregorian century rules for centuries after 1700
    function automatic int unsigned leap_days_through(int unsigned p);
        int unsigned n;
        n = p / 4;
        if (p > 1700)
            n -= p / 100 - 17;
        if (p > 1600)
            n += (p - 1600) / 400;
        return n;
    endfunction

    // 0 = Sunday; day 1 of year 1 counts as 1
    function automatic int unsigned weekday_of_first(int unsigned m, int unsigned y);
        int unsigned count;
        count = (y - 1) * 365 + leap_days_through(y - 1) + day_of_year_first(m, y);
        if (count < MISSING_FIRST)
            return (count + 5) % 7;
        if (count >= MISSING_FIRST + MISSING_DAYS)
            return (count + 5 - MISSING_DAYS) % 7;
        return WEEKDAY_IN_GAP;
    endfunction

    // Queue the 42 slots that one request must produce.
    function automatic void predict_month_grid(month_t month, year_t year);
        int unsigned m;
        int unsigned y;
        int unsigned k;
        int unsigned day;
        bit          bad;
        bit          reform;
        grid_slot_t  s;
        m = month;
        y = year;
        bad    = (m < 1 || m > 12 || y < 1 || y > YEAR_LAST);
        reform = !bad && month == MONTH_SEP && y == JULIAN_LAST_YEAR;

        // an out-of-range request and the fixed reform month leave the state alone
        if (!bad && !reform)
        begin
            pred_first_wd  = wday_t'(weekday_of_first(m, y));
            pred_month_len = mlen_t'(month_length_of(m, y));
            pred_start_day = day_t'(ordinal_view ? day_of_year_first(m, y) : 1);
        end

        for (k = 0; k < GRID_SLOTS; k++)
        begin
            day = 0;
            if (reform)
            begin
                if (k >= SEPT_FIRST_SLOT && k <= SEPT_END_SLOT)
                    day = (ordinal_view ? SEPT_ORD_BASE : SEPT_DAY_BASE)
                        + ((k <= SEPT_SPLIT_SLOT) ? k - SEPT_FIRST_SLOT : k + SEPT_JUMP);
            end
            else if (!bad)
            begin
                if (k >= pred_first_wd && k - pred_first_wd < pred_month_len)
                    day = pred_start_day + (k - pred_first_wd);
            end
            s.day   = day_t'(day);
            s.blank = (day == 0);
            s.pos   = slot_idx_t'(k);
            s.bad   = bad;
            s.last  = (k == GRID_SLOTS - 1);
            expected_slots.push_back(s);
        end

        requests_sent++;
        if (bad)
            bad_requests++;
        if (reform)
            reform_grids++;
        if (ordinal_view)
            ordinal_grids++;
    endfunction

    // ------------------------------------------------------------------
    // Slot checker and receiver back-pressure.
    // Values are read at the rising edge before this edge's nonblocking
    // updates land, so a transfer is exactly valid & ready seen here.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : slot_check
        grid_slot_t want;
        if (rst_n && slot_ch.valid && slot_ch.ready)
        begin
            if (expected_slots.size() == 0)
            begin
                $error("slot transfer at position %0d with no request pending",
                       slot_ch.slot_position);
                mismatches++;
            end
            else
            begin
                want = expected_slots.pop_front();
                slots_checked++;
                if (slot_ch.slot_day !== want.day)
                begin
                    $error("slot_day mismatch: expected %0d, actual %0d",
                           want.day, slot_ch.slot_day);
                    mismatches++;
                end
                if (slot_ch.slot_blank !== want.blank)
                begin
                    $error("slot_blank mismatch: expected %0b, actual %0b",
                           want.blank, slot_ch.slot_blank);
                    mismatches++;
                end
                if (slot_ch.slot_position !== want.pos)
                begin
                    $error("slot_position mismatch: expected %0d, actual %0d",
                           want.pos, slot_ch.slot_position);
                    mismatches++;
                end
                if (slot_ch.bad_request !== want.bad)
                begin
                    $error("bad_request mismatch: expected %0b, actual %0b",
                           want.bad, slot_ch.bad_request);
                    mismatches++;
                end
                if (slot_ch.last_slot !== want.last)
                begin
                    $error("last_slot mismatch: expected %0b, actual %0b",
                           want.last, slot_ch.last_slot);
                    mismatches++;
                end
            end
        end
        // per-cycle stall draw keeps gaps landing on every slot of the grid
        slot_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // One request transfer. valid is left high on return so a back-to-back
    // request never lowers and raises it within one time step.
    task automatic send_request(month_t month, year_t year);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.month_number <= month;
        req_ch.year_number  <= year;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // transfer happened at this edge
        predict_month_grid(month, year);
    endtask

    // Stop sending and wait until every predicted slot has come back.
    task automatic drain_slots();
        req_ch.valid <= 1'b0;
        while (expected_slots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; only issued once the core has gone quiet.
    task automatic write_ordinal_mode(bit mode);
        drain_slots();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        ordinal_view = mode;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes: first and last valid month and year, and bad months
    // and years including all-zero and all-ones fields.
    task automatic test_field_extremes();
        send_request(MONTH_JAN, YEAR_MIN);
        send_request(MONTH_DEC, YEAR_MAX);
        send_request(4'd0, 14'd2024);
        send_request(4'd15, 14'd2024);
        send_request(4'd13, YEAR_MIN);
        send_request(4'd6, 14'd0);
        send_request(4'd6, 14'd10000);
        send_request(4'd15, 14'd16383);
        send_request(MONTH_FEB, 14'd8191);
        drain_slots();
    endtask

    // February across the Julian and Gregorian century rules.
    task automatic test_leap_rules();
        send_request(MONTH_FEB, 14'd1600);
        send_request(MONTH_FEB, 14'd1700);   // Julian: leap
        send_request(MONTH_FEB, 14'd1800);   // Gregorian: common
        send_request(MONTH_FEB, 14'd1900);
        send_request(MONTH_FEB, 14'd2000);
        send_request(4'd3, 14'd2023);
        drain_slots();
    endtask

    // Months around the calendar switch, including the fixed September 1752.
    task automatic test_reform_switch(bit mode);
        write_ordinal_mode(mode);
        send_request(4'd8, REFORM_YEAR);
        send_request(MONTH_SEP, REFORM_YEAR);
        send_request(MONTH_OCT, REFORM_YEAR);
        send_request(MONTH_SEP, 14'd1751);
        send_request(MONTH_JAN, 14'd1753);
        drain_slots();
    endtask

    // Random requests: mostly valid months, weighted toward the switch
    // years and century Februaries and Marches, with a share of out-of-range requests.
    task automatic test_random_traffic(int unsigned count, int unsigned idle_pct,
                                       int unsigned stall_pct, bit mode);
        int unsigned n;
        int unsigned pick;
        month_t      m;
        year_t       y;
        write_ordinal_mode(mode);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 66)
            begin
                m = month_t'($urandom_range(1, 12));
                y = year_t'($urandom_range(1, YEAR_LAST));
            end
            else if (pick < 72)
            begin
                m = month_t'($urandom_range(8, 10));
                y = REFORM_YEAR;
            end
            else if (pick < 80)
            begin
                m = month_t'($urandom_range(1, 12));
                y = year_t'($urandom_range(1745, 1760));
            end
            else if (pick < 87)
            begin
                m = month_t'($urandom_range(2, 3));
                y = year_t'(100 * $urandom_range(1, 99));
            end
            else if (pick < 93)
            begin
                // bad month, any year
                m = ($urandom_range(3) == 0) ? 4'd0 : month_t'($urandom_range(13, 15));
                y = year_t'($urandom_range(0, 16383));
            end
            else
            begin
                // good month, bad year
                m = month_t'($urandom_range(1, 12));
                y = ($urandom_range(3) == 0) ? 14'd0 : year_t'($urandom_range(10000, 16383));
            end
            send_request(m, y);
        end
        drain_slots();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.month_number = '0;
        req_ch.year_number  = '0;
        slot_ch.ready       = 1'b0;
        ordinal_view        = 1'b0;
        pred_first_wd       = '0;
        pred_month_len      = '0;
        pred_start_day      = '0;
        send_idle_pct       = 22;
        recv_stall_pct      = 45;
        mismatches          = 0;
        requests_sent       = 0;
        bad_requests        = 0;
        reform_grids        = 0;
        ordinal_grids       = 0;
        slots_checked       = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs with the register at its reset value first
        test_field_extremes();
        test_leap_rules();
        test_reform_switch(1'b1);
        test_reform_switch(1'b0);

        // sender idles 22 / receiver 45, then swapped, then no idling
        test_random_traffic(RANDOM_PER_PHASE, 22, 45, 1'b1);
        test_random_traffic(RANDOM_PER_PHASE, 45, 22, 1'b0);
        test_random_traffic(RANDOM_PER_PHASE - 5, 0, 0, 1'b1);

        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d month requests (%0d out of range, %0d Sep 1752 grids,",
                 requests_sent, bad_requests, reform_grids);
        $display("  %0d in day-of-year view); %0d slot transfers checked.",
                 ordinal_grids, slots_checked);
        if (mismatches == 0 && expected_slots.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: stops a run that does not finish, even with stalls.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[month_calendar_grid_core.f]
src/mcg_pkg.sv
src/mcg_if.sv
src/mcg_front.sv
src/mcg_queue.sv
src/mcg_back.sv
src/month_calendar_grid_core.sv
dv/month_calendar_grid_core_test.sv
